FILE: sv/screen_sleep_led_pattern_macros.svh
// Assertion macros shared by the screen sleep LED pattern design.
`ifndef SCREEN_SLEEP_LED_PATTERN_MACROS_SVH
`define SCREEN_SLEEP_LED_PATTERN_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSLP_ASSERT_IMP(label, clock, resetn, pre, post) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (pre) |-> (post)) \
        else $error("screen_sleep_led_pattern: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSLP_ASSERT_NEXT(label, clock, resetn, pre, post) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (pre) |=> (post)) \
        else $error("screen_sleep_led_pattern: next-cycle check failed");

`endif

FILE: sv/sslp_pkg.sv
// Types, constants and helper functions for the screen sleep LED pattern block.
package sslp_pkg;

    typedef logic [23:0] rgb_t;

    typedef struct packed {
        logic [31:0] now;
        logic        relay;
        logic        user;
    } tick_t;

    // Register select taken from paddr[2].
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_MODE    = 1'b1;

    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_BLIP    = 3'd1;
    localparam logic [2:0] MODE_BREATHE = 3'd2;
    localparam logic [2:0] MODE_RAINBOW = 3'd3;
    localparam logic [2:0] MODE_BICOLOR = 3'd4;

    localparam logic [7:0] TIMEOUT_RESET = 8'd5;
    localparam logic [2:0] MODE_RESET    = MODE_BLIP;

    localparam logic [15:0] MS_PER_MIN  = 16'd60000;
    localparam logic [31:0] BLINK_MS    = 32'd500;
    localparam logic [31:0] BLIP_GAP_MS = 32'd4000;
    localparam logic [31:0] BLIP_ON_MS  = 32'd150;
    localparam logic [31:0] BICOLOR_MS  = 32'd3000;
    localparam logic [7:0]  BREATH_FLOOR = 8'd12;

    // now mod 12000 is built as 32 * ((now >> 5) mod 375) + now[4:0].
    localparam logic [26:0] RECIP_375   = 27'd91625968;  // floor(2^35 / 375)
    localparam int          RECIP_SHIFT = 35;
    localparam logic [8:0]  STEP_375    = 9'd375;

    localparam logic [13:0] STEP_MS     = 14'd2000;
    localparam logic [13:0] HALF_BREATH = 14'd2000;
    localparam logic [13:0] FULL_BREATH = 14'd4000;

    // floor(9 * t / 100) = (t * 94374) >> 20 for t up to 2000.
    localparam logic [16:0] BREATH_MUL   = 17'd94374;
    localparam int          BREATH_SHIFT = 20;
    // floor(255 * local / 2000) = (local * 2139096) >> 24 for local below 2000.
    localparam logic [21:0] FADE_MUL   = 22'd2139096;
    localparam int          FADE_SHIFT = 24;

    localparam rgb_t COLOR_OFF   = 24'h000000;
    localparam rgb_t COLOR_RED   = 24'hFF0000;
    localparam rgb_t COLOR_GREEN = 24'h00FF00;
    localparam rgb_t COLOR_BLUE  = 24'h0000FF;

    localparam rgb_t RAINBOW_TAB [6] = '{
        24'h00FF00, 24'h00FFFF, 24'h0000FF,
        24'hFF00FF, 24'hFF0000, 24'hFFFF00
    };

    // Channels are either 0 or 255, so the crossfade is f, 255 - f or constant.
    function automatic logic [7:0] fade_chan(logic [7:0] a, logic [7:0] b, logic [7:0] f);
        logic [7:0] r;
        if (a == b)
            r = a;
        else if (b > a)
            r = f;
        else
            r = 8'hFF - f;
        return r;
    endfunction

endpackage

FILE: sv/screen_sleep_led_pattern.sv
// Screen sleep timer with a sleep-time RGB status LED pattern generator.
`include "screen_sleep_led_pattern_macros.svh"

// Takes one tick beat per clock cycle while the output is not stalled and returns
// one result beat per tick. The time-only parts of the patterns (breathing level and
// rainbow crossfade) are worked out in four pipeline stages ahead of the state stage;
// the wake, sleep and blink state is updated once per tick in the state stage, which
// is what sets the rate of one tick per cycle. The pipeline stalls as a whole while a
// finished result waits on m_axis_tready. Registers at byte 0 (timeout in minutes, 0
// never sleeps) and byte 4 (LED mode) are to be written only while no tick is in
// flight; the block itself does not enforce this.
module screen_sleep_led_pattern
    import sslp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Tick input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // now_ms[31:0], relay_active[32], user_activity[33]
    // Result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16], backlight[24]
);

    // Configuration registers
    logic [7:0] timeout_reg;
    logic [2:0] mode_reg;

    // Pipeline registers
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    tick_t       tick1_reg, tick2_reg, tick3_reg, tick4_reg, tick5_reg;
    logic [18:0] quot_reg;
    logic [13:0] pos_reg;
    logic [2:0]  from_reg;
    logic [10:0] local_reg;
    logic [11:0] ph_reg;
    logic [7:0]  breath_reg;
    rgb_t        rainbow_reg;

    // Block state
    logic [31:0] last_act_reg, last_act_next;
    logic        asleep_reg, asleep_next;
    logic        relay_seen_reg;
    logic [31:0] timer_reg, timer_next;
    logic        phase_reg, phase_next;
    rgb_t        color_reg, color_next;

    // Output register
    logic        out_valid_reg;
    rgb_t        out_color_reg;
    logic        out_backlight_reg;

    logic adv;
    logic wake;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign pready        = 1'b1;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            mode_reg    <= MODE_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_TIMEOUT: timeout_reg <= pwdata[7:0];
                REG_MODE:    mode_reg    <= pwdata[2:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_TIMEOUT: prdata = {24'd0, timeout_reg};
            REG_MODE:    prdata = {29'd0, mode_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------ time-only stages
    logic [53:0] quot_prod;
    logic [27:0] quot_back;
    logic [26:0] rem_wide;
    logic [9:0]  rem_raw;
    logic [8:0]  rem_fix;
    logic [2:0]  from_c;
    logic [13:0] local_wide;
    logic [13:0] ph_wide;
    logic [10:0] tri_ms;
    logic [27:0] breath_prod;
    logic [32:0] fade_prod;
    logic [7:0]  fade_f;
    logic [2:0]  to_idx;
    rgb_t        rb_from, rb_to;

    always_comb
    begin
        quot_prod = 54'(tick1_reg.now[31:5]) * 54'(RECIP_375);

        quot_back = 28'(quot_reg) * 28'(STEP_375);
        rem_wide  = tick2_reg.now[31:5] - quot_back[26:0];
        rem_raw   = rem_wide[9:0];
        // The estimated quotient is low by at most one.
        rem_fix   = (rem_raw >= 10'(STEP_375)) ? 9'(rem_raw - 10'(STEP_375)) : rem_raw[8:0];

        if (pos_reg >= 14'(5 * STEP_MS))
            from_c = 3'd5;
        else if (pos_reg >= 14'(4 * STEP_MS))
            from_c = 3'd4;
        else if (pos_reg >= 14'(3 * STEP_MS))
            from_c = 3'd3;
        else if (pos_reg >= 14'(2 * STEP_MS))
            from_c = 3'd2;
        else if (pos_reg >= STEP_MS)
            from_c = 3'd1;
        else
            from_c = 3'd0;
        local_wide = pos_reg - 14'(from_c) * STEP_MS;
        if (pos_reg >= 14'(2 * FULL_BREATH))
            ph_wide = pos_reg - 14'(2 * FULL_BREATH);
        else if (pos_reg >= FULL_BREATH)
            ph_wide = pos_reg - FULL_BREATH;
        else
            ph_wide = pos_reg;

        // Triangle: rising for the first half, falling for the second.
        tri_ms      = (14'(ph_reg) < HALF_BREATH) ? ph_reg[10:0]
                                                  : 11'(FULL_BREATH - 14'(ph_reg));
        breath_prod = 28'(tri_ms) * 28'(BREATH_MUL);
        fade_prod   = 33'(local_reg) * 33'(FADE_MUL);
        fade_f      = fade_prod[FADE_SHIFT +: 8];
        to_idx      = (from_reg == 3'd5) ? 3'd0 : from_reg + 3'd1;
        rb_from     = RAINBOW_TAB[from_reg];
        rb_to       = RAINBOW_TAB[to_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tick1_reg.now   <= s_axis_tdata[31:0];
            tick1_reg.relay <= s_axis_tdata[32];
            tick1_reg.user  <= s_axis_tdata[33];

            tick2_reg <= tick1_reg;
            quot_reg  <= quot_prod[RECIP_SHIFT +: 19];

            tick3_reg <= tick2_reg;
            pos_reg   <= {rem_fix, tick2_reg.now[4:0]};

            tick4_reg <= tick3_reg;
            from_reg  <= from_c;
            local_reg <= local_wide[10:0];
            ph_reg    <= ph_wide[11:0];

            tick5_reg   <= tick4_reg;
            breath_reg  <= BREATH_FLOOR + breath_prod[BREATH_SHIFT +: 8];
            rainbow_reg <= {fade_chan(rb_from[23:16], rb_to[23:16], fade_f),
                            fade_chan(rb_from[15:8],  rb_to[15:8],  fade_f),
                            fade_chan(rb_from[7:0],   rb_to[7:0],   fade_f)};
        end
    end

    // ------------------------------------------------------------ state stage
    logic [23:0] limit_ms;
    logic [31:0] idle_ms;
    logic [31:0] elapsed;
    logic        blink_phase;
    logic        bicolor_phase;

    always_comb
    begin
        wake          = tick5_reg.user || (tick5_reg.relay && !relay_seen_reg);
        last_act_next = wake ? tick5_reg.now : last_act_reg;
        asleep_next   = asleep_reg && !wake;
        color_next    = (wake && asleep_reg) ? COLOR_OFF : color_reg;
        timer_next    = timer_reg;
        phase_next    = phase_reg;

        limit_ms = 24'(timeout_reg) * 24'(MS_PER_MIN);
        idle_ms  = tick5_reg.now - last_act_next;
        if (!asleep_next && timeout_reg != 8'd0 && idle_ms >= 32'(limit_ms))
        begin
            asleep_next = 1'b1;
            timer_next  = 32'd0;
            phase_next  = 1'b0;
        end

        elapsed       = tick5_reg.now - timer_next;
        blink_phase   = !phase_next;
        bicolor_phase = !phase_next;

        if (!asleep_next)
            color_next = COLOR_OFF;
        else if (tick5_reg.relay)
        begin
            if (elapsed >= BLINK_MS)
            begin
                timer_next = tick5_reg.now;
                phase_next = blink_phase;
                color_next = blink_phase ? COLOR_RED : COLOR_OFF;
            end
        end
        else
        begin
            case (mode_reg)
                MODE_BLIP:
                begin
                    if (!phase_next && elapsed >= BLIP_GAP_MS)
                    begin
                        timer_next = tick5_reg.now;
                        phase_next = 1'b1;
                        color_next = COLOR_GREEN;
                    end
                    else if (phase_next && elapsed >= BLIP_ON_MS)
                    begin
                        timer_next = tick5_reg.now;
                        phase_next = 1'b0;
                        color_next = COLOR_OFF;
                    end
                end
                MODE_BREATHE: color_next = {8'd0, breath_reg, 8'd0};
                MODE_RAINBOW: color_next = rainbow_reg;
                MODE_BICOLOR:
                begin
                    if (elapsed >= BICOLOR_MS)
                    begin
                        timer_next = tick5_reg.now;
                        phase_next = bicolor_phase;
                        color_next = bicolor_phase ? COLOR_BLUE : COLOR_GREEN;
                    end
                end
                default: color_next = COLOR_OFF;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_act_reg   <= 32'd0;
            asleep_reg     <= 1'b0;
            relay_seen_reg <= 1'b0;
            timer_reg      <= 32'd0;
            phase_reg      <= 1'b0;
            color_reg      <= COLOR_OFF;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= v5_reg;
            if (v5_reg)
            begin
                last_act_reg   <= last_act_next;
                asleep_reg     <= asleep_next;
                relay_seen_reg <= tick5_reg.relay;
                timer_reg      <= timer_next;
                phase_reg      <= phase_next;
                color_reg      <= color_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_color_reg     <= color_next;
            out_backlight_reg <= !asleep_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_backlight_reg, out_color_reg[7:0],
                            out_color_reg[15:8], out_color_reg[23:16]};

    // ------------------------------------------------------------- assertions
    `SSLP_ASSERT_IMP(a_awake_led_off, clk, rst_n,
        out_valid_reg && out_backlight_reg, out_color_reg == COLOR_OFF)
    `SSLP_ASSERT_NEXT(a_backlight_tracks_sleep, clk, rst_n,
        adv && v5_reg, out_backlight_reg == !asleep_reg)
    `SSLP_ASSERT_NEXT(a_sleep_held_without_wake, clk, rst_n,
        adv && v5_reg && asleep_reg && !wake, asleep_reg)
    `SSLP_ASSERT_IMP(a_stall_blocks_input, clk, rst_n,
        out_valid_reg && !m_axis_tready, !s_axis_tready)

endmodule
